### rtl/core/circle_from_three_points_assert.svh
// Assertion macros for the circle pipeline RTL, used by the queue (cftp_fifo).
// They expect clk_i and rst_ni to be visible where they are used.
`ifndef CIRCLE_FROM_THREE_POINTS_ASSERT_SVH
`define CIRCLE_FROM_THREE_POINTS_ASSERT_SVH

// The condition must never hold at a clock edge.
`define CFTP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// When pre holds, post must hold in the following cycle.
`define CFTP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/cftp_pkg.sv
// ----------------------------------------------------------------------------
// cftp_pkg
// Shared constants and width helpers for the circle-through-three-points core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cftp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int THR_W           = 34;
  localparam int OUT_W           = 32;
  localparam int ROOT_W          = 32;
  localparam int SQ_IN_W         = 64;
  localparam int FIFO_DEPTH      = 4;
  localparam int APB_ADDR_W      = 4;
  localparam int APB_DATA_W      = 64;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
  localparam logic [OUT_W-1:0] OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

  // Register index, taken from address bit 3 (registers sit at 8*i).
  localparam logic REG_THR = 1'b0;

  function automatic int num_w(input int w);
    return 3 * w + 4;
  endfunction

  function automatic int den_w(input int w);
    return 2 * w + 4;
  endfunction

  function automatic int sq_w(input int w);
    return 2 * w + 2;
  endfunction

  function automatic int ent_w(input int w);
    return 1 + 2 * num_w(w) + den_w(w) + 2 * (w + 1) + sq_w(w);
  endfunction

endpackage

`default_nettype wire

### rtl/core/cftp_fifo.sv
// ----------------------------------------------------------------------------
// cftp_fifo
// Short register queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "circle_from_three_points_assert.svh"

module cftp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `CFTP_ASSERT_NEVER(a_no_overflow, push_i && full_o && !pop_i, "queue overflow")
  `CFTP_ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "queue underflow")
  `CFTP_ASSERT_NEXT(a_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "count slip")

endmodule

`default_nettype wire

### rtl/core/cftp_front.sv
// ----------------------------------------------------------------------------
// cftp_front
// Takes items, forms differences and products, and decides between the
// circumcircle and the diameter fallback.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cftp_front #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         in_valid_i,
  output logic                                              in_ready_o,
  input  wire logic [5:0][cftp_pkg::FIELD_W-1:0]            crd_i,
  input  wire logic [cftp_pkg::THR_W-1:0]                   thr_i,
  input  wire logic                                         full_i,
  output logic                                              push_o,
  output logic [cftp_pkg::ent_w(COORD_WIDTH)-1:0]           ent_o
);
  import cftp_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int DW1   = W + 1;
  localparam int PW    = 2 * W + 2;
  localparam int SQW   = sq_w(W);
  localparam int CRW   = 2 * W + 3;
  localparam int NUMW  = num_w(W);
  localparam int DENW  = den_w(W);
  localparam int CMPW  = (THR_W > CRW) ? THR_W : CRW;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en         = !(v4_q && full_i);
  assign in_ready_o = en;
  assign push_o     = v4_q && !full_i;

  // Stage 1: coordinates.
  logic signed [W-1:0] c1_q [6];
  logic signed [W:0]   ext [6];

  for (genvar i = 0; i < 6; i++) begin : g_ext
    assign ext[i] = DW1'(c1_q[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        c1_q[i] <= signed'(W'(crd_i[i]));
      end
    end
  end

  // Stage 2: differences, products and squared lengths.
  logic signed [W:0]   bx, by, cx, cy, ex, ey;
  logic signed [PW-1:0] sbx, sby, scx, scy, sex, sey;
  logic signed [W:0]   bx_q, by_q, cx_q, cy_q;
  logic signed [PW-1:0] pbxcy_q, pbycx_q;
  logic [SQW-1:0]      bb_q, cc_q, d23_q;
  logic signed [W:0]   s12x_q, s12y_q, s13x_q, s13y_q, s23x_q, s23y_q, x1_q, y1_q;

  assign bx  = ext[2] - ext[0];
  assign by  = ext[3] - ext[1];
  assign cx  = ext[4] - ext[0];
  assign cy  = ext[5] - ext[1];
  assign ex  = ext[4] - ext[2];
  assign ey  = ext[5] - ext[3];
  assign sbx = bx * bx;
  assign sby = by * by;
  assign scx = cx * cx;
  assign scy = cy * cy;
  assign sex = ex * ex;
  assign sey = ey * ey;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bx_q    <= bx;
      by_q    <= by;
      cx_q    <= cx;
      cy_q    <= cy;
      pbxcy_q <= bx * cy;
      pbycx_q <= by * cx;
      bb_q    <= SQW'(unsigned'(sbx)) + SQW'(unsigned'(sby));
      cc_q    <= SQW'(unsigned'(scx)) + SQW'(unsigned'(scy));
      d23_q   <= SQW'(unsigned'(sex)) + SQW'(unsigned'(sey));
      s12x_q  <= ext[0] + ext[2];
      s12y_q  <= ext[1] + ext[3];
      s13x_q  <= ext[0] + ext[4];
      s13y_q  <= ext[1] + ext[5];
      s23x_q  <= ext[2] + ext[4];
      s23y_q  <= ext[3] + ext[5];
      x1_q    <= ext[0];
      y1_q    <= ext[1];
    end
  end

  // Stage 3: cross product and numerator products.
  logic signed [SQW:0]    bbs, ccs;
  logic signed [CRW-1:0]  cross_q;
  logic signed [NUMW-1:0] pcybb_q, pbycc_q, pbxcc_q, pcxbb_q;
  logic [SQW-1:0]         bb3_q, cc3_q, d233_q;
  logic signed [W:0]      t12x_q, t12y_q, t13x_q, t13y_q, t23x_q, t23y_q, x13_q, y13_q;

  assign bbs = signed'({1'b0, bb_q});
  assign ccs = signed'({1'b0, cc_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      cross_q <= CRW'(pbxcy_q) - CRW'(pbycx_q);
      pcybb_q <= cy_q * bbs;
      pbycc_q <= by_q * ccs;
      pbxcc_q <= bx_q * ccs;
      pcxbb_q <= cx_q * bbs;
      bb3_q   <= bb_q;
      cc3_q   <= cc_q;
      d233_q  <= d23_q;
      t12x_q  <= s12x_q;
      t12y_q  <= s12y_q;
      t13x_q  <= s13x_q;
      t13y_q  <= s13y_q;
      t23x_q  <= s23x_q;
      t23y_q  <= s23y_q;
      x13_q   <= x1_q;
      y13_q   <= y1_q;
    end
  end

  // Stage 4: classification and fallback selection.
  logic [CRW-1:0]         mag;
  logic                   coll, sel12, sel13;
  logic signed [W:0]      fbx, fby, basex, basey;
  logic [SQW-1:0]         dd;
  logic [ent_w(W)-1:0]    ent_q;

  assign mag   = cross_q[CRW-1] ? unsigned'(-cross_q) : unsigned'(cross_q);
  assign coll  = (cross_q == '0) || (CMPW'(mag) < CMPW'(thr_i));
  assign sel12 = (bb3_q >= cc3_q) && (bb3_q >= d233_q);
  assign sel13 = (cc3_q >= bb3_q) && (cc3_q >= d233_q);

  always_comb begin
    if (sel12) begin
      fbx = t12x_q;
      fby = t12y_q;
      dd  = bb3_q;
    end else if (sel13) begin
      fbx = t13x_q;
      fby = t13y_q;
      dd  = cc3_q;
    end else begin
      fbx = t23x_q;
      fby = t23y_q;
      dd  = d233_q;
    end
    basex = coll ? fbx : x13_q;
    basey = coll ? fby : y13_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q <= {coll, NUMW'(pcybb_q - pbycc_q), NUMW'(pbxcc_q - pcxbb_q),
                DENW'({cross_q, 1'b0}), basex, basey, dd};
    end
  end

  assign ent_o = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cftp_div.sv
// ----------------------------------------------------------------------------
// cftp_div
// Two-lane pipelined restoring divider, one quotient bit per stage, rounding
// to nearest with ties away from zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cftp_div #(
  parameter int NUM_W  = 52,
  parameter int DEN_W  = 36,
  parameter int SIDE_W = 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [NUM_W-1:0] num_x_i,
  input  wire logic signed [NUM_W-1:0] num_y_i,
  input  wire logic signed [DEN_W-1:0] den_i,
  input  wire logic [SIDE_W-1:0]       side_i,
  output logic                         valid_o,
  output logic signed [NUM_W+9:0]      quo_x_o,
  output logic signed [NUM_W+9:0]      quo_y_o,
  output logic [SIDE_W-1:0]            side_o
);
  localparam int NW   = NUM_W + 9;
  localparam int DW   = DEN_W + 1;
  localparam int LAST = NW + 2;

  logic [LAST:0]       v_q;
  logic [SIDE_W-1:0]   side_q [LAST+1];
  logic [DEN_W-1:0]    ud_q;
  logic [DW-1:0]       d2_q [NW+1];
  logic signed [NUM_W-1:0] num_in [2];
  logic signed [NW:0]      quo [2];

  assign num_in[0] = num_x_i;
  assign num_in[1] = num_y_i;
  assign quo_x_o   = quo[0];
  assign quo_y_o   = quo[1];
  assign valid_o   = v_q[LAST];
  assign side_o    = side_q[LAST];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ud_q      <= den_i[DEN_W-1] ? unsigned'(-den_i) : unsigned'(den_i);
      side_q[0] <= side_i;
      d2_q[0]   <= {ud_q, 1'b0};
      for (int k = 0; k < NW; k++) begin
        d2_q[k+1] <= d2_q[k];
      end
      for (int k = 0; k < LAST; k++) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [NUM_W-1:0] u_q;
    logic             neg_q [NW+2];
    logic [NW-1:0]    nsh_q [NW+1];
    logic [DW-1:0]    rem_q [NW+1];
    logic [NW-1:0]    q_q   [NW+1];
    logic signed [NW:0] out_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        u_q      <= num_in[l][NUM_W-1] ? unsigned'(-num_in[l]) : unsigned'(num_in[l]);
        neg_q[0] <= num_in[l][NUM_W-1] ^ den_i[DEN_W-1];
        for (int k = 0; k < NW + 1; k++) begin
          neg_q[k+1] <= neg_q[k];
        end
        nsh_q[0] <= (NW'(u_q) << 9) + NW'(ud_q);
        rem_q[0] <= '0;
        q_q[0]   <= '0;
        out_q    <= neg_q[NW+1] ? -signed'({1'b0, q_q[NW]}) : signed'({1'b0, q_q[NW]});
      end
    end

    for (genvar k = 0; k < NW; k++) begin : g_step
      logic [DW:0] trial;
      logic        take;
      assign trial = {rem_q[k], nsh_q[k][NW-1]};
      assign take  = (trial >= {1'b0, d2_q[k]});
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= take ? DW'(trial - {1'b0, d2_q[k]}) : trial[DW-1:0];
          nsh_q[k+1] <= nsh_q[k] << 1;
          q_q[k+1]   <= {q_q[k][NW-2:0], take};
        end
      end
    end

    assign quo[l] = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[LAST-1:0], valid_i};
    end
  end

endmodule

`default_nettype wire

### rtl/core/cftp_sqrt.sv
// ----------------------------------------------------------------------------
// cftp_sqrt
// Pipelined digit-by-digit square root with rounding to nearest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cftp_sqrt #(
  parameter int SIDE_W = 1
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [cftp_pkg::SQ_IN_W-1:0]   s_i,
  input  wire logic [SIDE_W-1:0]              side_i,
  output logic                                valid_o,
  output logic [cftp_pkg::ROOT_W:0]           root_o,
  output logic [SIDE_W-1:0]                   side_o
);
  import cftp_pkg::*;

  localparam int SW   = ROOT_W;
  localparam int RW   = SW + 2;
  localparam int LAST = SW + 1;

  logic [LAST:0]         v_q;
  logic [SIDE_W-1:0]     side_q [LAST+1];
  logic [SQ_IN_W-1:0]    sh_q   [SW+1];
  logic [RW-1:0]         rem_q  [SW+1];
  logic [SW-1:0]         root_q [SW+1];
  logic [SW:0]           out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sh_q[0]   <= s_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
      for (int k = 0; k < LAST; k++) begin
        side_q[k+1] <= side_q[k];
      end
      out_q <= (SW+1)'(root_q[SW]) + (SW+1)'(rem_q[SW] > RW'(root_q[SW]));
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_step
    logic [RW+1:0] trial_rem;
    logic [RW+1:0] trial;
    logic          take;
    assign trial_rem = {rem_q[k], sh_q[k][SQ_IN_W-1 -: 2]};
    assign trial     = (RW+2)'({root_q[k], 2'b01});
    assign take      = (trial_rem >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? RW'(trial_rem - trial) : RW'(trial_rem);
        root_q[k+1] <= {root_q[k][SW-2:0], take};
        sh_q[k+1]   <= sh_q[k] << 2;
      end
    end
  end

  assign valid_o = v_q[LAST];
  assign root_o  = out_q;
  assign side_o  = side_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[LAST-1:0], valid_i};
    end
  end

endmodule

`default_nettype wire

### rtl/core/cftp_back.sv
// ----------------------------------------------------------------------------
// cftp_back
// Divides for the center, clamps, takes the radius root and drives the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cftp_back #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [cftp_pkg::ent_w(COORD_WIDTH)-1:0] ent_i,
  input  wire logic                                empty_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [3*cftp_pkg::OUT_W-1:0]             out_data_o,
  output logic [1:0]                               out_user_o
);
  import cftp_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int NUMW  = num_w(W);
  localparam int DENW  = den_w(W);
  localparam int SQW   = sq_w(W);
  localparam int NW    = NUMW + 9;
  localparam int OXW   = NW + 2;
  localparam int DSW   = 1 + 2 * (W + 1) + SQW;
  localparam int SSW   = 2 * OUT_W + 3;

  logic en;
  logic out_valid_q;
  logic [3*OUT_W-1:0] out_data_q;
  logic [1:0]         out_user_q;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // Queue entry fields.
  logic                   e_coll;
  logic signed [NUMW-1:0] e_nx, e_ny;
  logic signed [DENW-1:0] e_den;
  logic [2*(W+1)+SQW-1:0] e_rest;

  assign {e_coll, e_nx, e_ny, e_den, e_rest} = ent_i;

  logic                 dv;
  logic signed [NW:0]   qx, qy;
  logic [DSW-1:0]       dside;

  cftp_div #(
    .NUM_W  (NUMW),
    .DEN_W  (DENW),
    .SIDE_W (DSW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (!empty_i),
    .num_x_i (e_nx),
    .num_y_i (e_ny),
    .den_i   (e_den),
    .side_i  ({e_coll, e_rest}),
    .valid_o (dv),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .side_o  (dside)
  );

  logic              d_coll;
  logic signed [W:0] d_bx, d_by;
  logic [SQW-1:0]    d_dd;

  assign {d_coll, d_bx, d_by, d_dd} = dside;

  // P1: center sum and quotient magnitudes.
  logic signed [OXW-1:0] bxe, bye;
  logic                  p1v_q, p1coll_q;
  logic signed [OXW-1:0] ox_q, oy_q;
  logic [NW-1:0]         ax_q, ay_q;
  logic [SQW-1:0]        p1dd_q;

  assign bxe = OXW'(d_bx);
  assign bye = OXW'(d_by);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q     <= d_coll ? (bxe <<< 7) : (bxe <<< 8) + OXW'(qx);
      oy_q     <= d_coll ? (bye <<< 7) : (bye <<< 8) + OXW'(qy);
      ax_q     <= NW'(qx[NW] ? -qx : qx);
      ay_q     <= NW'(qy[NW] ? -qy : qy);
      p1coll_q <= d_coll;
      p1dd_q   <= d_dd;
    end
  end

  // P2: clamp the center and square the offsets.
  logic               fitx, fity;
  logic [OUT_W-1:0]   cx_q, cy_q;
  logic               satc_q, big_q, p2coll_q;
  logic [2*OUT_W-1:0] sqx_q, sqy_q;
  logic [SQW-1:0]     p2dd_q;

  assign fitx = (&ox_q[OXW-1:OUT_W-1]) || !(|ox_q[OXW-1:OUT_W-1]);
  assign fity = (&oy_q[OXW-1:OUT_W-1]) || !(|oy_q[OXW-1:OUT_W-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q     <= fitx ? ox_q[OUT_W-1:0] : (ox_q[OXW-1] ? OUT_MIN : OUT_MAX);
      cy_q     <= fity ? oy_q[OUT_W-1:0] : (oy_q[OXW-1] ? OUT_MIN : OUT_MAX);
      satc_q   <= !fitx || !fity;
      big_q    <= (|ax_q[NW-1:OUT_W]) || (|ay_q[NW-1:OUT_W]);
      sqx_q    <= ax_q[OUT_W-1:0] * ax_q[OUT_W-1:0];
      sqy_q    <= ay_q[OUT_W-1:0] * ay_q[OUT_W-1:0];
      p2coll_q <= p1coll_q;
      p2dd_q   <= p1dd_q;
    end
  end

  // P3: radicand.
  logic [2*OUT_W:0]    sum;
  logic [SQ_IN_W-1:0]  s_q;
  logic [SSW-1:0]      sside_q;

  assign sum = (2*OUT_W+1)'(sqx_q) + (2*OUT_W+1)'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q     <= p2coll_q ? SQ_IN_W'({p2dd_q, 14'b0}) : sum[SQ_IN_W-1:0];
      sside_q <= {cx_q, cy_q, satc_q, p2coll_q,
                  !p2coll_q && (big_q || sum[2*OUT_W])};
    end
  end

  logic p1v_d;
  logic p2v_q, p3v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1v_q <= 1'b0;
      p2v_q <= 1'b0;
      p3v_q <= 1'b0;
    end else if (en) begin
      p1v_q <= p1v_d;
      p2v_q <= p1v_q;
      p3v_q <= p2v_q;
    end
  end

  assign p1v_d = dv;

  logic              sv;
  logic [ROOT_W:0]   root;
  logic [SSW-1:0]    sside;

  cftp_sqrt #(
    .SIDE_W (SSW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p3v_q),
    .s_i     (s_q),
    .side_i  (sside_q),
    .valid_o (sv),
    .root_o  (root),
    .side_o  (sside)
  );

  logic [OUT_W-1:0] f_cx, f_cy;
  logic             f_satc, f_coll, f_ovf;
  logic [ROOT_W:0]  rad;

  assign {f_cx, f_cy, f_satc, f_coll, f_ovf} = sside;
  assign rad = f_ovf ? {1'b1, {ROOT_W{1'b0}}} : root;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {(rad[ROOT_W] ? {OUT_W{1'b1}} : rad[OUT_W-1:0]), f_cy, f_cx};
      out_user_q <= {f_satc || rad[ROOT_W], f_coll};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sv;
    end
  end

endmodule

`default_nettype wire

### rtl/core/circle_from_three_points.sv
// ----------------------------------------------------------------------------
// circle_from_three_points
// Circle through three Q8.8 points: circumcenter and radius in Q16.16, with a
// diameter fallback for nearly collinear points.
// Throughput: one item per cycle while the output is not stalled; the divider
// and root pipelines take a new operand every enabled cycle, and a four-entry
// queue decouples front from back end. A stalled result holds the whole back
// end; the front keeps filling the queue until it is full. Reset clears all
// valid flags and sets collinear_threshold to 1.
`timescale 1ns / 1ps
`default_nettype none

module circle_from_three_points #(
  parameter int COORD_WIDTH = cftp_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  wire logic [6*cftp_pkg::FIELD_W-1:0]    s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // center_x, center_y, radius
  output logic [3*cftp_pkg::OUT_W-1:0]           m_tdata,
  // collinear, saturated
  output logic [1:0]                             m_tuser,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [cftp_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [cftp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cftp_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import cftp_pkg::*;

  localparam int EW = ent_w(COORD_WIDTH);

  logic [THR_W-1:0] thr_q;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_THR) ? APB_DATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[3] == REG_THR) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  logic                        full, empty, push, pop;
  logic [EW-1:0]               ent_in, ent_out;
  logic [5:0][FIELD_W-1:0]     crd;

  assign crd = s_tdata;

  cftp_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .crd_i      (crd),
    .thr_i      (thr_q),
    .full_i     (full),
    .push_o     (push),
    .ent_o      (ent_in)
  );

  cftp_fifo #(
    .WIDTH (EW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ent_in),
    .pop_i   (pop),
    .data_o  (ent_out),
    .full_o  (full),
    .empty_o (empty)
  );

  cftp_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (ent_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_o  (m_tdata),
    .out_user_o  (m_tuser)
  );

endmodule

`default_nettype wire

### bench/circle_from_three_points_tb.sv
// ----------------------------------------------------------------------------
// circle_from_three_points_tb
// Streams random and corner-case triangles through the circle core, predicts
// each circle in the bench, and compares every result field, with random
// gaps on both stream sides and several collinear threshold settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circle_from_three_points_tb;
  import cftp_pkg::*;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        rad;
    logic               coll;
    logic               sat;
  } circle_t;

  class circle_scoreboard;
    circle_t     pending[$];
    logic [33:0] threshold;
    int          errors;

    function new();
      threshold = THR_RESET;
      errors = 0;
    endfunction

    function longint unsigned root_round(longint unsigned s);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      if (s > res) res++;
      return res;
    endfunction

    function longint quot_round(longint n, longint d);
      longint unsigned un, ud, q;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = (2 * un + ud) / (2 * ud);
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function void note_triangle(logic [95:0] pts);
      longint p[6];
      longint bx, by, qx, qy, cr, bb, cc, dx, dy, ox, oy, d12, d13, d23, ax, ay, ex, ey, dd;
      longint unsigned mag, rad, sx, sy, s;
      circle_t r;
      for (int i = 0; i < 6; i++) p[i] = longint'($signed(pts[16*i +: 16]));
      bx = p[2] - p[0]; by = p[3] - p[1];
      qx = p[4] - p[0]; qy = p[5] - p[1];
      cr = bx * qy - by * qx;
      mag = cr < 0 ? -cr : cr;
      r.coll = 0;
      r.sat = 0;
      if (cr == 0 || mag < threshold) begin
        d12 = bx * bx + by * by;
        d13 = qx * qx + qy * qy;
        d23 = (p[4] - p[2]) ** 2 + (p[5] - p[3]) ** 2;
        if (d12 >= d13 && d12 >= d23) begin
          ax = p[0]; ay = p[1]; ex = p[2]; ey = p[3]; dd = d12;
        end else if (d13 >= d12 && d13 >= d23) begin
          ax = p[0]; ay = p[1]; ex = p[4]; ey = p[5]; dd = d13;
        end else begin
          ax = p[2]; ay = p[3]; ex = p[4]; ey = p[5]; dd = d23;
        end
        r.coll = 1;
        ox = (ax + ex) * 128;
        oy = (ay + ey) * 128;
        rad = root_round(unsigned'(dd) << 14);
      end else begin
        bb = bx * bx + by * by;
        cc = qx * qx + qy * qy;
        dx = quot_round((qy * bb - by * cc) * 256, 2 * cr);
        dy = quot_round((bx * cc - qx * bb) * 256, 2 * cr);
        ox = p[0] * 256 + dx;
        oy = p[1] * 256 + dy;
        if (dx >= 64'sd4294967296 || dx <= -64'sd4294967296 ||
            dy >= 64'sd4294967296 || dy <= -64'sd4294967296) begin
          rad = 64'd1 << 32;
        end else begin
          sx = dx * dx;
          sy = dy * dy;
          s = sx + sy;
          rad = (s < sx) ? 64'd1 << 32 : root_round(s);
        end
      end
      if (ox > 64'sd2147483647) begin ox = 64'sd2147483647; r.sat = 1; end
      if (ox < -64'sd2147483648) begin ox = -64'sd2147483648; r.sat = 1; end
      if (oy > 64'sd2147483647) begin oy = 64'sd2147483647; r.sat = 1; end
      if (oy < -64'sd2147483648) begin oy = -64'sd2147483648; r.sat = 1; end
      if (rad > 64'hFFFFFFFF) begin rad = 64'hFFFFFFFF; r.sat = 1; end
      r.cx = ox[31:0];
      r.cy = oy[31:0];
      r.rad = rad[31:0];
      pending = {pending, r};
    endfunction

    function void check_circle(logic [95:0] d, logic [1:0] u);
      circle_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.cx) begin
        $error("center_x expected %h got %h", e.cx, d[31:0]); errors++;
      end
      if (d[63:32] !== e.cy) begin
        $error("center_y expected %h got %h", e.cy, d[63:32]); errors++;
      end
      if (d[95:64] !== e.rad) begin
        $error("radius expected %h got %h", e.rad, d[95:64]); errors++;
      end
      if (u[0] !== e.coll) begin
        $error("collinear expected %b got %b", e.coll, u[0]); errors++;
      end
      if (u[1] !== e.sat) begin
        $error("saturated expected %b got %b", e.sat, u[1]); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [95:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic        pready;
  bit          calm = 0;
  circle_scoreboard board = new();

  circle_from_three_points dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // Result side: random stalls except during the calm stretch.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) board.check_circle(m_tdata, m_tuser);
    m_tready <= calm || ($urandom_range(99) >= 13);
  end

  task automatic write_threshold(logic [33:0] v);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= 64'(v);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.threshold = v;
  endtask

  task automatic send_triangle(logic [95:0] pts);
    if (!calm && $urandom_range(99) < 13) begin
      s_tvalid <= 0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < 13);
    end
    s_tvalid <= 1;
    s_tdata <= pts;
    do @(posedge clk_i); while (!s_tready);
    board.note_triangle(pts);
  endtask

  task automatic drain();
    int n = 0;
    s_tvalid <= 0;
    while (board.pending.size() != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (150) @(posedge clk_i);
  endtask

  function automatic logic [15:0] coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(512)) - 16'd256;
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(31)) << $urandom_range(11);
    endcase
  endfunction

  function automatic logic [95:0] random_triangle();
    logic [95:0] t;
    logic [15:0] dx, dy;
    int k;
    for (int i = 0; i < 6; i++) t[16*i +: 16] = coord();
    if ($urandom_range(3) == 0) begin
      // Nearly or exactly collinear: third point on the line through the others.
      dx = t[47:32] - t[15:0];
      dy = t[63:48] - t[31:16];
      k = $urandom_range(2);
      t[79:64] = t[15:0] + (k == 0 ? dx : k == 1 ? -dx : dx >>> 1);
      t[95:80] = t[31:16] + (k == 0 ? dy : k == 1 ? -dy : dy >>> 1)
                 + 16'($urandom_range(1));
    end
    return t;
  endfunction

  logic [33:0] thresholds[5] = '{34'd0, 34'h3FFFFFFFF, 34'd1000, 34'd65536, 34'd1};

  initial begin
    logic [95:0] t;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed corners at the reset threshold.
    send_triangle({16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000});
    send_triangle('0);
    send_triangle({6{16'h7FFF}});
    send_triangle({6{16'h8000}});
    send_triangle({16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000});
    send_triangle({16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000});
    send_triangle({16'h0300, 16'h0300, 16'h0200, 16'h0200, 16'h0100, 16'h0100});
    send_triangle({16'h0200, 16'h0200, 16'h0100, 16'h0100, 16'h0300, 16'h0300});
    send_triangle({16'h0000, 16'h0100, 16'h0000, 16'h0200, 16'h0000, 16'h0000});
    send_triangle({16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000});
    send_triangle({16'h0001, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h0000});
    send_triangle({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0100});
    send_triangle({16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0100});
    send_triangle({16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000});
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(thresholds[ph]);
      calm = (ph == 2);
      send_triangle({16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000});
      send_triangle({16'h0300, 16'h0300, 16'h0200, 16'h0200, 16'h0100, 16'h0100});
      for (int i = 0; i < 80; i++) begin
        t = random_triangle();
        send_triangle(t);
      end
      calm = 0;
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("circle_from_three_points_tb: clean");
    end else begin
      $display("circle_from_three_points_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("circle_from_three_points_tb: errors");
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/cftp_pkg.sv
rtl/core/cftp_fifo.sv
rtl/core/cftp_front.sv
rtl/core/cftp_div.sv
rtl/core/cftp_sqrt.sv
rtl/core/cftp_back.sv
rtl/core/circle_from_three_points.sv
bench/circle_from_three_points_tb.sv
